@@ rtl/core/kbh_pkg.sv @@
// Package for the key bigram histogram: table dimensions, field and address
// types, operation codes, controller states and index/saturation helpers.
// No dependencies.
`timescale 1ns / 1ps

package kbh_pkg;

  // Built table dimensions and counter width
  localparam int LAYERS      = 2;
  localparam int ROWS        = 8;
  localparam int COLS        = 16;
  localparam int COUNT_WIDTH = 32;

  localparam int KEY_DEPTH   = LAYERS * ROWS * COLS;
  localparam int PLANE_DEPTH = ROWS * COLS;
  localparam int PAIR_DEPTH  = KEY_DEPTH * PLANE_DEPTH;

  localparam int KEY_AW  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int PAIR_AW = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;

  typedef logic [2:0]             layer_t;
  typedef logic [3:0]             row_t;
  typedef logic [4:0]             col_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [KEY_AW-1:0]      key_addr_t;
  typedef logic [PAIR_AW-1:0]     pair_addr_t;

  typedef enum logic [1:0] {
    OP_TAP       = 2'd0,
    OP_QUERY_KEY = 2'd1,
    OP_QUERY_BI  = 2'd2,
    OP_UNUSED    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  function automatic logic key_in_range(layer_t layer, row_t row, col_t col);
    return (int'(layer) < LAYERS) && (int'(row) < ROWS) && (int'(col) < COLS);
  endfunction

  function automatic logic pos_in_range(row_t row, col_t col);
    return (int'(row) < ROWS) && (int'(col) < COLS);
  endfunction

  function automatic key_addr_t key_index(layer_t layer, row_t row, col_t col);
    return KEY_AW'((int'(layer) * ROWS + int'(row)) * COLS + int'(col));
  endfunction

  function automatic pair_addr_t pair_index(key_addr_t first, row_t row, col_t col);
    return PAIR_AW'(int'(first) * PLANE_DEPTH + int'(row) * COLS + int'(col));
  endfunction

  // Saturating increment
  function automatic count_t bump(count_t value);
    return (value == '1) ? value : value + count_t'(1);
  endfunction

endpackage

@@ rtl/core/kbh_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only on a read enable. No dependencies.
`timescale 1ns / 1ps

module kbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/key_bigram_histogram.sv @@
// Top level of the key bigram histogram: controller, two count memories and
// the output register. Depends on kbh_pkg and kbh_ram.
`timescale 1ns / 1ps

// Counts taps per key (layer, row, col) and bigrams (previous key, current
// row and col) in two memories, and answers queries for either count. After
// reset the block runs a clearing pass over all PAIR_DEPTH entries (32768
// with the built dimensions), zeroing both memories, with s_axis_tready_o
// low. Then, for each item, in the accept cycle (ST_IDLE) the addresses are
// formed and both memories are read; in ST_EXEC the read data arrives, the
// saturating increment is written back and the result is loaded into the
// output register. The read is registered, so a new item is accepted only
// after the last one is written back, though a result may still wait in
// the output register; an item that finds the register still full holds in
// ST_EXEC until the result is taken. Keys outside the built dimensions
// return count 0 with status 1 and change nothing; operation code 3 returns
// count 0 with status 0. The first tap after reset counts no bigram.
module key_bigram_histogram (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] key_layer, [6:3] key_row, [11:7] key_col, [15:12] next_row,
  // [20:16] next_col, [23:21] zero
  input  logic [23:0] s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] count
  output logic [31:0] m_axis_tdata_o,
  // [0] status
  output logic [0:0]  m_axis_tuser_o
);

  // Input field split
  kbh_pkg::op_e    in_op;
  kbh_pkg::layer_t in_layer;
  kbh_pkg::row_t   in_row;
  kbh_pkg::col_t   in_col;
  kbh_pkg::row_t   in_nrow;
  kbh_pkg::col_t   in_ncol;

  assign in_op    = kbh_pkg::op_e'(s_axis_tuser_i);
  assign in_layer = s_axis_tdata_i[2:0];
  assign in_row   = s_axis_tdata_i[6:3];
  assign in_col   = s_axis_tdata_i[11:7];
  assign in_nrow  = s_axis_tdata_i[15:12];
  assign in_ncol  = s_axis_tdata_i[20:16];

  // Controller state
  kbh_pkg::state_e     state_q, state_d;
  kbh_pkg::pair_addr_t clr_q, clr_d;

  // Item registers, held from accept to write-back
  kbh_pkg::op_e        op_q;
  logic                ok_q;
  logic                pair_en_q;
  kbh_pkg::key_addr_t  key_addr_q;
  kbh_pkg::pair_addr_t pair_addr_q;

  // Previous tap
  kbh_pkg::key_addr_t  prev_key_q;
  logic                prev_valid_q;

  // Output register
  logic                out_valid_q, out_valid_d;
  kbh_pkg::count_t     out_count_q, out_count_d;
  logic                out_status_q, out_status_d;

  // Memory ports
  logic                key_we, key_re;
  kbh_pkg::key_addr_t  key_waddr, key_raddr;
  kbh_pkg::count_t     key_wdata, key_rdata;
  logic                pair_we, pair_re;
  kbh_pkg::pair_addr_t pair_waddr, pair_raddr;
  kbh_pkg::count_t     pair_wdata, pair_rdata;

  logic                accept;
  logic                in_ok;
  kbh_pkg::key_addr_t  in_key;
  logic                out_free;
  kbh_pkg::count_t     key_bumped;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_key   = kbh_pkg::key_index(in_layer, in_row, in_col);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign key_bumped = kbh_pkg::bump(key_rdata);

  // Bound check; a bigram query also checks the second key's position
  always_comb begin
    in_ok = kbh_pkg::key_in_range(in_layer, in_row, in_col);
    if (in_op == kbh_pkg::OP_QUERY_BI) begin
      in_ok = in_ok && kbh_pkg::pos_in_range(in_nrow, in_ncol);
    end
  end

  // Read addresses: a tap reads the bigram after the previous key, a bigram
  // query reads the one after the queried first key
  assign key_raddr  = in_key;
  assign pair_raddr = (in_op == kbh_pkg::OP_TAP)
                      ? kbh_pkg::pair_index(prev_key_q, in_row, in_col)
                      : kbh_pkg::pair_index(in_key, in_nrow, in_ncol);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kbh_pkg::ST_CLEAR;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      prev_key_q   <= '0;
      prev_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      // Advance the previous key on every tap that lands in the table
      if (accept && in_op == kbh_pkg::OP_TAP && in_ok) begin
        prev_key_q   <= in_key;
        prev_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
    if (accept) begin
      op_q        <= in_op;
      ok_q        <= in_ok;
      pair_en_q   <= (in_op == kbh_pkg::OP_TAP) && prev_valid_q;
      key_addr_q  <= in_key;
      pair_addr_q <= pair_raddr;
    end
  end

  // Next state, memory control and result
  always_comb begin
    state_d         = state_q;
    clr_d           = clr_q;
    s_axis_tready_o = 1'b0;
    key_re          = 1'b0;
    pair_re         = 1'b0;
    key_we          = 1'b0;
    pair_we         = 1'b0;
    key_waddr       = key_addr_q;
    pair_waddr      = pair_addr_q;
    key_wdata       = key_bumped;
    pair_wdata      = kbh_pkg::bump(pair_rdata);
    out_valid_d     = out_valid_q && !m_axis_tready_i;
    out_count_d     = out_count_q;
    out_status_d    = out_status_q;

    unique case (state_q)
      kbh_pkg::ST_CLEAR: begin
        // Zero one pair entry per cycle; the key memory rides along
        key_waddr  = clr_q[kbh_pkg::KEY_AW-1:0];
        pair_waddr = clr_q;
        key_wdata  = '0;
        pair_wdata = '0;
        pair_we    = 1'b1;
        key_we     = int'(clr_q) < kbh_pkg::KEY_DEPTH;
        clr_d      = clr_q + kbh_pkg::pair_addr_t'(1);
        if (clr_q == kbh_pkg::pair_addr_t'(kbh_pkg::PAIR_DEPTH - 1)) begin
          state_d = kbh_pkg::ST_IDLE;
        end
      end
      kbh_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          key_re  = 1'b1;
          pair_re = 1'b1;
          state_d = kbh_pkg::ST_EXEC;
        end
      end
      kbh_pkg::ST_EXEC: begin
        // Hold here, read data stable, until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = kbh_pkg::ST_IDLE;
          if (op_q == kbh_pkg::OP_UNUSED) begin
            out_count_d  = '0;
            out_status_d = 1'b0;
          end else if (!ok_q) begin
            out_count_d  = '0;
            out_status_d = 1'b1;
          end else begin
            out_status_d = 1'b0;
            unique case (op_q)
              kbh_pkg::OP_TAP: begin
                out_count_d = key_bumped;
                key_we      = 1'b1;
                pair_we     = pair_en_q;
              end
              kbh_pkg::OP_QUERY_KEY: out_count_d = key_rdata;
              default:               out_count_d = pair_rdata;
            endcase
          end
        end
      end
      default: state_d = kbh_pkg::ST_IDLE;
    endcase
  end

  kbh_ram #(
    .WIDTH(kbh_pkg::COUNT_WIDTH),
    .DEPTH(kbh_pkg::KEY_DEPTH)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(key_wdata),
    .re_i   (key_re),
    .raddr_i(key_raddr),
    .rdata_o(key_rdata)
  );

  kbh_ram #(
    .WIDTH(kbh_pkg::COUNT_WIDTH),
    .DEPTH(kbh_pkg::PAIR_DEPTH)
  ) u_pair_ram (
    .clk_i  (clk_i),
    .we_i   (pair_we),
    .waddr_i(pair_waddr),
    .wdata_i(pair_wdata),
    .re_i   (pair_re),
    .raddr_i(pair_raddr),
    .rdata_o(pair_rdata)
  );

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = 32'(out_count_q);
  assign m_axis_tuser_o[0] = out_status_q;

  // An accepted transfer always moves to the write-back cycle
  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == kbh_pkg::ST_EXEC))
    else $error("accepted item did not reach write-back");

  // A flagged result carries no count
  a_status_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("out-of-range result with nonzero count");

  // Memories stay untouched while waiting for an item
  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kbh_pkg::ST_IDLE) |-> (!key_we && !pair_we))
    else $error("memory write while idle");

  // A result appears only out of the write-back cycle
  a_out_from_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == kbh_pkg::ST_EXEC))
    else $error("result loaded outside write-back");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for key_bigram_histogram: stream driver, result monitor
// and a tap/bigram count predictor with its own copy of both tables.
// Depends on kbh_pkg and the key_bigram_histogram RTL.
`timescale 1ns / 1ps

module testbench;
  import kbh_pkg::*;

  localparam int RANDOM_ITEMS = 1740;
  localparam int HOT_KEYS     = 5;
  localparam int TAIL_ITEMS   = 150;

  // One key request as it travels on the slave stream, plus a flag that makes
  // the driver hold it back until every earlier result has been returned.
  typedef struct packed {
    op_e    op;
    layer_t layer;
    row_t   row;
    col_t   col;
    row_t   nrow;
    col_t   ncol;
    logic   wait_idle;
  } key_req_t;

  typedef struct packed {
    count_t count;
    logic   status;
  } count_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_TAP;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;

  // Predictor state: per-key tap totals, bigram totals and the last tapped key
  count_t      tap_totals  [KEY_DEPTH]  = '{default: '0};
  count_t      pair_totals [PAIR_DEPTH] = '{default: '0};
  int unsigned last_key;
  logic        last_key_valid = 1'b0;

  key_req_t      req_q[$];
  count_result_t counts_due_q[$];
  key_req_t      cur_req;

  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned send_gap;
  int unsigned stall_left;
  logic        tail_phase;
  int          fail_n = 0;

  // Coverage tallies for the closing summary
  int n_taps = 0, n_key_q = 0, n_bi_q = 0, n_bi_hits = 0, n_outside = 0, n_unused = 0;

  key_bigram_histogram dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hold reset from time zero, then release it on a rising edge.
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic fits_tables(key_req_t r);
    return (r.layer < LAYERS) && (r.row < ROWS) && (r.col < COLS);
  endfunction

  function automatic count_t saturate_up(count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Advance the predicted tables by one request and return its result.
  function automatic count_result_t histogram_step(key_req_t r);
    count_result_t res;
    int unsigned   key_ix;
    int unsigned   pair_ix;
    logic          hit;
    res = '{count: '0, status: 1'b0};
    if (r.op == OP_UNUSED) begin
      n_unused++;
      return res;
    end
    hit = fits_tables(r);
    if (r.op == OP_QUERY_BI) hit = hit && (r.nrow < ROWS) && (r.ncol < COLS);
    if (!hit) begin
      n_outside++;
      res.status = 1'b1;
      return res;
    end
    key_ix = (r.layer * ROWS + r.row) * COLS + r.col;
    case (r.op)
      OP_TAP: begin
        n_taps++;
        tap_totals[key_ix] = saturate_up(tap_totals[key_ix]);
        res.count = tap_totals[key_ix];
        // Current layer is dropped: the bigram plane is indexed by row and col only.
        if (last_key_valid) begin
          pair_ix = last_key * PLANE_DEPTH + r.row * COLS + r.col;
          pair_totals[pair_ix] = saturate_up(pair_totals[pair_ix]);
        end
        last_key       = key_ix;
        last_key_valid = 1'b1;
      end
      OP_QUERY_KEY: begin
        n_key_q++;
        res.count = tap_totals[key_ix];
      end
      default: begin
        n_bi_q++;
        pair_ix   = key_ix * PLANE_DEPTH + r.nrow * COLS + r.ncol;
        res.count = pair_totals[pair_ix];
        if (res.count != 0) n_bi_hits++;
      end
    endcase
    return res;
  endfunction

  function automatic key_req_t mk_req(op_e op, int layer, int row, int col, int nrow, int ncol);
    key_req_t r;
    r.op        = op;
    r.layer     = layer_t'(layer);
    r.row       = row_t'(row);
    r.col       = col_t'(col);
    r.nrow      = row_t'(nrow);
    r.ncol      = col_t'(ncol);
    r.wait_idle = 1'b0;
    return r;
  endfunction

  function automatic key_req_t place_in_tables(key_req_t r);
    r.layer = layer_t'($urandom_range(0, LAYERS - 1));
    r.row   = row_t'($urandom_range(0, ROWS - 1));
    r.col   = col_t'($urandom_range(0, COLS - 1));
    return r;
  endfunction

  // Driver: present the next pending request whenever the slot is free, run the
  // predictor on every transfer, and insert random idle bursts outside the tail.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    key_req_t    nxt;
    int unsigned sent_now;
    if (!rst_ni) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      s_tuser    <= OP_TAP;
      send_gap   <= 0;
      items_sent <= 0;
      tail_phase <= 1'b0;
    end else begin
      sent_now = items_sent;
      if (s_tvalid && s_tready) begin
        counts_due_q.push_back(histogram_step(cur_req));
        sent_now = items_sent + 1;
        items_sent <= sent_now;
      end
      tail_phase <= (req_q.size() < TAIL_ITEMS);
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (req_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (req_q[0].wait_idle && results_seen != sent_now) begin
          // Drain the block completely before this request goes out.
          s_tvalid <= 1'b0;
        end else begin
          nxt = req_q.pop_front();
          cur_req  <= nxt;
          s_tvalid <= 1'b1;
          s_tdata  <= {3'b000, nxt.ncol, nxt.nrow, nxt.col, nxt.row, nxt.layer};
          s_tuser  <= nxt.op;
          if (req_q.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0)
            send_gap <= $urandom_range(1, 12);
        end
      end
    end
  end

  // Monitor: stall the result stream in random bursts and check every transfer
  // against the oldest predicted result.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    count_result_t want;
    if (!rst_ni) begin
      m_tready     <= 1'b0;
      stall_left   <= 0;
      results_seen <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (counts_due_q.size() == 0) begin
          $error("unexpected result: count=%0d status=%0d", m_tdata, m_tuser);
          fail_n++;
        end else begin
          want = counts_due_q.pop_front();
          if (m_tdata !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, m_tdata);
            fail_n++;
          end
          if (m_tuser[0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser[0]);
            fail_n++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 11);
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin : run
    key_req_t r;
    key_req_t hot [HOT_KEYS];
    key_req_t bigram_log[$];
    key_req_t gen_prev;
    logic     gen_prev_ok;
    int       pick, sel, useful_n;

    // Directed: empty tables, first tap, table corners, dropped layer,
    // out-of-range keys, ignored next fields and the unused operation.
    req_q.push_back(mk_req(OP_QUERY_KEY, 0, 0, 0, 0, 0));
    req_q.push_back(mk_req(OP_QUERY_BI, 0, 0, 0, 0, 0));
    req_q.push_back(mk_req(OP_TAP, 0, 0, 0, 0, 0));
    req_q.push_back(mk_req(OP_QUERY_BI, 0, 0, 0, 0, 0));
    req_q.push_back(mk_req(OP_TAP, 1, 7, 15, 0, 0));
    req_q.push_back(mk_req(OP_QUERY_BI, 0, 0, 0, 7, 15));
    req_q.push_back(mk_req(OP_TAP, 1, 7, 15, 15, 31));
    req_q.push_back(mk_req(OP_TAP, 0, 7, 15, 0, 0));
    req_q.push_back(mk_req(OP_QUERY_BI, 1, 7, 15, 7, 15));
    req_q.push_back(mk_req(OP_QUERY_KEY, 1, 7, 15, 15, 31));
    req_q.push_back(mk_req(OP_TAP, 2, 0, 0, 0, 0));
    req_q.push_back(mk_req(OP_TAP, 7, 15, 31, 15, 31));
    req_q.push_back(mk_req(OP_TAP, 0, 8, 0, 0, 0));
    req_q.push_back(mk_req(OP_TAP, 0, 0, 16, 0, 0));
    req_q.push_back(mk_req(OP_QUERY_KEY, 7, 15, 31, 0, 0));
    req_q.push_back(mk_req(OP_QUERY_KEY, 1, 0, 31, 0, 0));
    req_q.push_back(mk_req(OP_QUERY_BI, 0, 0, 0, 8, 0));
    req_q.push_back(mk_req(OP_QUERY_BI, 0, 0, 0, 0, 16));
    req_q.push_back(mk_req(OP_QUERY_BI, 1, 7, 15, 15, 31));
    req_q.push_back(mk_req(OP_UNUSED, 7, 15, 31, 15, 31));
    req_q.push_back(mk_req(OP_TAP, 0, 0, 1, 15, 31));
    req_q.push_back(mk_req(OP_QUERY_BI, 0, 7, 15, 0, 1));
    req_q.push_back(mk_req(OP_QUERY_KEY, 0, 0, 1, 0, 0));

    // Random: mostly in-range taps over a few hot keys so bigrams repeat, with
    // queries aimed at recorded pairs; the rest is raw field noise.
    foreach (hot[i]) hot[i] = place_in_tables(mk_req(OP_TAP, 0, 0, 0, 0, 0));
    gen_prev    = mk_req(OP_TAP, 0, 0, 1, 0, 0);
    gen_prev_ok = 1'b1;
    useful_n    = 0;
    while (useful_n < RANDOM_ITEMS) begin
      r = mk_req(OP_TAP, $urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 31),
                 $urandom_range(0, 15), $urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 19);
      if (pick < 55) begin
        if (sel < 15) begin
          sel     = $urandom_range(0, HOT_KEYS - 1);
          r.layer = hot[sel].layer;
          r.row   = hot[sel].row;
          r.col   = hot[sel].col;
        end else if (sel < 19) begin
          r = place_in_tables(r);
        end
        if (fits_tables(r)) begin
          if (gen_prev_ok) begin
            bigram_log.push_back(mk_req(OP_QUERY_BI, gen_prev.layer, gen_prev.row,
                                        gen_prev.col, r.row, r.col));
            if (bigram_log.size() > 64) void'(bigram_log.pop_front());
          end
          gen_prev    = r;
          gen_prev_ok = 1'b1;
        end
      end else if (pick < 75) begin
        r.op = OP_QUERY_KEY;
        if (sel < 14) begin
          sel     = $urandom_range(0, HOT_KEYS - 1);
          r.layer = hot[sel].layer;
          r.row   = hot[sel].row;
          r.col   = hot[sel].col;
        end else if (sel < 18) begin
          r = place_in_tables(r);
        end
      end else if (pick < 95) begin
        if (sel < 12 && bigram_log.size() != 0) begin
          r = bigram_log[$urandom_range(0, bigram_log.size() - 1)];
        end else if (sel < 17) begin
          r      = place_in_tables(r);
          r.nrow = row_t'($urandom_range(0, ROWS - 1));
          r.ncol = col_t'($urandom_range(0, COLS - 1));
        end
        r.op = OP_QUERY_BI;
      end else begin
        r.op = OP_UNUSED;
      end
      if (r.op != OP_UNUSED) useful_n++;
      r.wait_idle = (useful_n % 450 == 1);
      req_q.push_back(r);
    end

    // Let everything go out, then wait for the last result and let the block settle.
    do @(posedge clk_i); while (req_q.size() != 0 || s_tvalid);
    while (results_seen != items_sent) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (counts_due_q.size() != 0) begin
      $error("%0d results never arrived", counts_due_q.size());
      fail_n++;
    end

    $display("Covered %0d taps, %0d key and %0d bigram queries (%0d bigram hits),",
             n_taps, n_key_q, n_bi_q, n_bi_hits);
    $display("%0d out-of-range requests and %0d unused-operation requests.",
             n_outside, n_unused);
    if (fail_n == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: clearing pass plus every transfer at its worst gap and stall, several times over.
  initial begin
    #(8_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
